@@ sv/vml_pkg.sv @@
// shared constants, microcode format and control program of the velocity limiter
package vml_pkg;

  localparam int unsigned VelWidthDef = 16;
  localparam int unsigned MaxSpdBits  = 15;
  localparam logic [MaxSpdBits-1:0] MaxSpdReset = 15'd1280;

  localparam int unsigned PcW   = 4;
  localparam int unsigned OpW   = 4;
  localparam int unsigned CondW = 3;
  localparam int unsigned CntLdW = 2;

  // datapath operations
  localparam logic [OpW-1:0] OP_NOP    = 4'd0;
  localparam logic [OpW-1:0] OP_ACCEPT = 4'd1;
  localparam logic [OpW-1:0] OP_SQX    = 4'd2;
  localparam logic [OpW-1:0] OP_SQY    = 4'd3;
  localparam logic [OpW-1:0] OP_SUM    = 4'd4;
  localparam logic [OpW-1:0] OP_SQRT   = 4'd5;
  localparam logic [OpW-1:0] OP_CMP    = 4'd6;
  localparam logic [OpW-1:0] OP_DIV_LD = 4'd7;
  localparam logic [OpW-1:0] OP_DIV    = 4'd8;
  localparam logic [OpW-1:0] OP_FINX   = 4'd9;
  localparam logic [OpW-1:0] OP_FINY   = 4'd10;
  localparam logic [OpW-1:0] OP_OUT    = 4'd11;

  // sequencing conditions
  localparam logic [CondW-1:0] C_NEXT     = 3'd0;
  localparam logic [CondW-1:0] C_WAIT_IN  = 3'd1;
  localparam logic [CondW-1:0] C_LOOP     = 3'd2;
  localparam logic [CondW-1:0] C_SKIP_NC  = 3'd3;
  localparam logic [CondW-1:0] C_WAIT_OUT = 3'd4;
  localparam logic [CondW-1:0] C_JUMP     = 3'd5;

  // step counter loads
  localparam logic [CntLdW-1:0] CNT_NONE = 2'd0;
  localparam logic [CntLdW-1:0] CNT_SQRT = 2'd1;
  localparam logic [CntLdW-1:0] CNT_DIV  = 2'd2;

  // program addresses that are jump targets or watched
  localparam logic [PcW-1:0] PC_ACCEPT = 4'd0;
  localparam logic [PcW-1:0] PC_SQRT   = 4'd4;
  localparam logic [PcW-1:0] PC_CMP    = 4'd5;
  localparam logic [PcW-1:0] PC_OUT    = 4'd11;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [CondW-1:0]  cond;
    logic [CntLdW-1:0] cnt_ld;
    logic [PcW-1:0]    target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           accept;
    logic           out_load;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic over_limit;
  } status_t;

  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_JUMP, cnt_ld: CNT_NONE, target: PC_ACCEPT};
    case (pc)
      4'd0:  w = '{op: OP_ACCEPT, cond: C_WAIT_IN,  cnt_ld: CNT_NONE, target: PC_ACCEPT};
      4'd1:  w = '{op: OP_SQX,    cond: C_NEXT,     cnt_ld: CNT_NONE, target: PC_ACCEPT};
      4'd2:  w = '{op: OP_SQY,    cond: C_NEXT,     cnt_ld: CNT_NONE, target: PC_ACCEPT};
      4'd3:  w = '{op: OP_SUM,    cond: C_NEXT,     cnt_ld: CNT_SQRT, target: PC_ACCEPT};
      4'd4:  w = '{op: OP_SQRT,   cond: C_LOOP,     cnt_ld: CNT_NONE, target: PC_ACCEPT};
      4'd5:  w = '{op: OP_CMP,    cond: C_SKIP_NC,  cnt_ld: CNT_NONE, target: PC_OUT};
      4'd6:  w = '{op: OP_DIV_LD, cond: C_NEXT,     cnt_ld: CNT_DIV,  target: PC_ACCEPT};
      4'd7:  w = '{op: OP_DIV,    cond: C_LOOP,     cnt_ld: CNT_NONE, target: PC_ACCEPT};
      4'd8:  w = '{op: OP_FINX,   cond: C_NEXT,     cnt_ld: CNT_DIV,  target: PC_ACCEPT};
      4'd9:  w = '{op: OP_DIV,    cond: C_LOOP,     cnt_ld: CNT_NONE, target: PC_ACCEPT};
      4'd10: w = '{op: OP_FINY,   cond: C_NEXT,     cnt_ld: CNT_NONE, target: PC_ACCEPT};
      4'd11: w = '{op: OP_OUT,    cond: C_WAIT_OUT, cnt_ld: CNT_NONE, target: PC_ACCEPT};
      default: ;
    endcase
    return w;
  endfunction

endpackage

@@ sv/vml_if.sv @@
// stream interfaces for adjustment items and velocity results
interface vml_in_if
  import vml_pkg::*;
#(
  parameter int unsigned VEL_WIDTH = VelWidthDef
);
  logic                        valid;
  logic                        ready;
  logic signed [VEL_WIDTH-1:0] x_adjust;
  logic signed [VEL_WIDTH-1:0] y_adjust;

  modport source (output valid, output x_adjust, output y_adjust, input ready);
  modport sink   (input valid, input x_adjust, input y_adjust, output ready);
endinterface

interface vml_out_if
  import vml_pkg::*;
#(
  parameter int unsigned VEL_WIDTH = VelWidthDef
);
  logic                        valid;
  logic                        ready;
  logic signed [VEL_WIDTH-1:0] vel_x;
  logic signed [VEL_WIDTH-1:0] vel_y;
  logic                        clamped;

  modport source (output valid, output vel_x, output vel_y, output clamped, input ready);
  modport sink   (input valid, input vel_x, input vel_y, input clamped, output ready);
endinterface

@@ sv/velocity_magnitude_limiter.sv @@
// Velocity magnitude limiter: adds adjustments to a stored 2-D velocity and clamps its length.
//
// in_i carries one item per transfer: x_adjust and y_adjust, signed fixed point.
// out_o carries one result per input item: vel_x, vel_y and clamped.
// cfg_we_i/cfg_wdata_i write the speed limit (15 bits, same fixed-point format); write
// only while no item is in flight.
// Each item is worked by a microcoded sequencer over a shared multiplier, a root unit
// that yields one bit a cycle and a divider that yields one quotient bit a cycle.
// When the limit is exceeded, compare is followed by two 15-bit divisions that scale x and y
// before the output load; otherwise compare goes straight to the output load. in_i.ready
// is high only in the accept step, so one item is at work at a time and the next may enter
// in the cycle after the previous result is loaded, as the sequencer then jumps to accept.
// The result sits in an output register: the next item is accepted and worked while
// the receiver stalls, and its final load waits until that register frees up.
// Reset clears the stored velocity to zero, sets the speed limit to 1280 (5.0) and
// empties the output register.
module velocity_magnitude_limiter
  import vml_pkg::*;
#(
  parameter int unsigned VEL_WIDTH = VelWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  vml_in_if.sink                in_i,
  vml_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [MaxSpdBits-1:0] cfg_wdata_i
);

  ctrl_t   ctrl;
  status_t status;

  assign in_i.ready = (ctrl.op == OP_ACCEPT);

  vml_sequencer #(
    .VEL_WIDTH(VEL_WIDTH)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .ctrl_o  (ctrl)
  );

  vml_datapath #(
    .VEL_WIDTH(VEL_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_i.valid),
    .x_adjust_i (in_i.x_adjust),
    .y_adjust_i (in_i.y_adjust),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .vel_x_o    (out_o.vel_x),
    .vel_y_o    (out_o.vel_y),
    .clamped_o  (out_o.clamped)
  );

endmodule

@@ sv/vml_sequencer.sv @@
// microcode sequencer: program counter, step counter and control store
module vml_sequencer
  import vml_pkg::*;
#(
  parameter int unsigned VEL_WIDTH = VelWidthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  localparam int unsigned MulW = (VEL_WIDTH > MaxSpdBits) ? VEL_WIDTH : MaxSpdBits;
  localparam int unsigned CntW = $clog2(MulW);
  localparam logic [CntW-1:0] SqrtLast = CntW'(VEL_WIDTH - 1);
  localparam logic [CntW-1:0] DivLast  = CntW'(MaxSpdBits - 1);

  logic [PcW-1:0]  pc_q, pc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  ucode_t          uw;
  logic [PcW-1:0]  pc_inc;

  assign uw     = ucode_rom(pc_q);
  assign pc_inc = pc_q + 1'b1;

  always_comb begin
    pc_d  = pc_q;
    cnt_d = cnt_q;
    unique case (uw.cond)
      C_NEXT:     pc_d = pc_inc;
      C_WAIT_IN:  pc_d = status_i.in_valid ? pc_inc : pc_q;
      C_LOOP: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end else begin
          pc_d = pc_inc;
        end
      end
      C_SKIP_NC:  pc_d = status_i.over_limit ? pc_inc : uw.target;
      C_WAIT_OUT: pc_d = status_i.out_busy ? pc_q : uw.target;
      C_JUMP:     pc_d = uw.target;
      default:    pc_d = PC_ACCEPT;
    endcase
    case (uw.cnt_ld)
      CNT_SQRT: cnt_d = SqrtLast;
      CNT_DIV:  cnt_d = DivLast;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PC_ACCEPT;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

  assign ctrl_o.op       = uw.op;
  assign ctrl_o.accept   = (uw.op == OP_ACCEPT) && status_i.in_valid;
  assign ctrl_o.out_load = (uw.op == OP_OUT) && !status_i.out_busy;

  // the root loop only leaves toward the compare step
  a_sqrt_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == PC_SQRT |=> pc_q == PC_SQRT || pc_q == PC_CMP)
    else $error("root loop left to a wrong step");

endmodule

@@ sv/vml_datapath.sv @@
// velocity registers, shared multiplier, root and divide step units, output register
module vml_datapath
  import vml_pkg::*;
#(
  parameter int unsigned VEL_WIDTH = VelWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ctrl_t                       ctrl_i,
  output status_t                     status_o,
  input  logic                        cfg_we_i,
  input  logic [MaxSpdBits-1:0]       cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic signed [VEL_WIDTH-1:0] x_adjust_i,
  input  logic signed [VEL_WIDTH-1:0] y_adjust_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [VEL_WIDTH-1:0] vel_x_o,
  output logic signed [VEL_WIDTH-1:0] vel_y_o,
  output logic                        clamped_o
);

  localparam int unsigned W    = VEL_WIDTH;
  localparam int unsigned QB   = MaxSpdBits;
  localparam int unsigned MulW = (W > QB) ? W : QB;
  localparam int unsigned PW   = W + MulW;

  logic [QB-1:0]        spd_lim_q;
  logic signed [W-1:0]  x_q, y_q;
  logic [PW-1:0]        prod_q;
  logic [2*W-1:0]       acc_q;
  logic [W:0]           srem_q;
  logic [W-1:0]         root_q;
  logic [W-1:0]         drem_q;
  logic [QB-1:0]        dq_q;
  logic                 clamp_q;
  logic                 out_valid_q;
  logic signed [W-1:0]  out_x_q, out_y_q;
  logic                 out_clamp_q;

  // saturating sums
  logic [W:0]           sum_x, sum_y;
  logic [W-1:0]         sat_x, sat_y;
  logic [W-1:0]         min_val, max_val;

  assign min_val = {1'b1, {(W-1){1'b0}}};
  assign max_val = {1'b0, {(W-1){1'b1}}};
  assign sum_x = {x_q[W-1], x_q} + {x_adjust_i[W-1], x_adjust_i};
  assign sum_y = {y_q[W-1], y_q} + {y_adjust_i[W-1], y_adjust_i};
  assign sat_x = (sum_x[W] != sum_x[W-1]) ? (sum_x[W] ? min_val : max_val) : sum_x[W-1:0];
  assign sat_y = (sum_y[W] != sum_y[W-1]) ? (sum_y[W] ? min_val : max_val) : sum_y[W-1:0];

  // magnitudes and shared multiplier
  logic [W-1:0]    ax, ay;
  logic [W-1:0]    mul_a;
  logic [MulW-1:0] mul_b;
  logic [PW-1:0]   mul_p;

  assign ax = x_q[W-1] ? W'(-x_q) : W'(x_q);
  assign ay = y_q[W-1] ? W'(-y_q) : W'(y_q);

  always_comb begin
    mul_a = ax;
    mul_b = MulW'(ax);
    case (ctrl_i.op)
      OP_SQY: begin
        mul_a = ay;
        mul_b = MulW'(ay);
      end
      OP_CMP: mul_b = MulW'(spd_lim_q);
      OP_DIV_LD: begin
        mul_a = ay;
        mul_b = MulW'(spd_lim_q);
      end
      default: ;
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // one root digit per step
  logic [W+2:0] sq_r, sq_t, sq_diff;
  logic         sq_bit;

  assign sq_r    = {srem_q, acc_q[2*W-1 -: 2]};
  assign sq_t    = {1'b0, root_q, 2'b01};
  assign sq_bit  = (sq_r >= sq_t);
  assign sq_diff = sq_r - sq_t;

  // one quotient bit per step
  logic [W:0] dv_r, dv_diff;
  logic       dv_bit;

  assign dv_r    = {drem_q, dq_q[QB-1]};
  assign dv_bit  = (dv_r >= {1'b0, root_q});
  assign dv_diff = dv_r - {1'b0, root_q};

  // quotient back into signed velocity, sign taken from the component
  logic [W-1:0] quo;
  logic [W-1:0] fin_x, fin_y;

  assign quo   = W'(MulW'(dq_q));
  assign fin_x = x_q[W-1] ? W'(-quo) : quo;
  assign fin_y = y_q[W-1] ? W'(-quo) : quo;

  assign status_o.in_valid   = in_valid_i;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;
  assign status_o.over_limit = MulW'(root_q) > MulW'(spd_lim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_lim_q   <= MaxSpdReset;
      x_q         <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        spd_lim_q <= cfg_wdata_i;
      end
      if (ctrl_i.accept) begin
        x_q <= sat_x;
        y_q <= sat_y;
      end else if (ctrl_i.op == OP_FINX) begin
        x_q <= fin_x;
      end else if (ctrl_i.op == OP_FINY) begin
        y_q <= fin_y;
      end
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_SQX: prod_q <= mul_p;
      OP_SQY: begin
        prod_q <= mul_p;
        acc_q  <= prod_q[2*W-1:0];
      end
      OP_SUM: begin
        acc_q  <= acc_q + prod_q[2*W-1:0];
        srem_q <= '0;
        root_q <= '0;
      end
      OP_SQRT: begin
        acc_q  <= {acc_q[2*W-3:0], 2'b00};
        srem_q <= sq_bit ? sq_diff[W:0] : sq_r[W:0];
        root_q <= {root_q[W-2:0], sq_bit};
      end
      OP_CMP: begin
        prod_q  <= mul_p;
        clamp_q <= status_o.over_limit;
      end
      OP_DIV_LD: begin
        prod_q <= mul_p;
        drem_q <= W'(prod_q[PW-1:QB]);
        dq_q   <= prod_q[QB-1:0];
      end
      OP_DIV: begin
        drem_q <= dv_bit ? dv_diff[W-1:0] : dv_r[W-1:0];
        dq_q   <= {dq_q[QB-2:0], dv_bit};
      end
      OP_FINX: begin
        drem_q <= W'(prod_q[PW-1:QB]);
        dq_q   <= prod_q[QB-1:0];
      end
      default: ;
    endcase
    if (ctrl_i.out_load) begin
      out_x_q     <= x_q;
      out_y_q     <= y_q;
      out_clamp_q <= clamp_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign vel_x_o     = out_x_q;
  assign vel_y_o     = out_y_q;
  assign clamped_o   = out_clamp_q;

  // a scaled component never exceeds the limit
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_FINX || ctrl_i.op == OP_FINY) |-> MulW'(dq_q) <= MulW'(spd_lim_q))
    else $error("scaled component above the speed limit");

  // a result only appears from an output load
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_i.out_load))
    else $error("result valid without a load");

endmodule

@@ tb/sv/vml_checker.sv @@
// scoreboard that predicts every velocity result of the limiter and compares it with the block
module vml_checker
  import vml_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  vml_in_if                     in_mon,
  vml_out_if                    out_mon,
  input  logic                  cfg_we_i,
  input  logic [MaxSpdBits-1:0] cfg_wdata_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW = VelWidthDef;
  localparam longint VelHi = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VelLo = -VelHi - 1;

  typedef logic signed [VW-1:0] vel_t;
  typedef struct packed {
    vel_t vx;
    vel_t vy;
    logic clamped;
  } velocity_t;

  velocity_t             expected_vel_q[$];
  vel_t                  cur_x;
  vel_t                  cur_y;
  logic [MaxSpdBits-1:0] speed_limit;
  int unsigned           mismatches;

  function automatic vel_t saturate_sum(vel_t acc, vel_t adj);
    longint s;
    s = longint'(acc) + longint'(adj);
    if (s > VelHi) begin
      s = VelHi;
    end else if (s < VelLo) begin
      s = VelLo;
    end
    return vel_t'(s);
  endfunction

  // integer square root, one result bit per pass from the top
  function automatic longint floor_root(longint n);
    longint r;
    longint cand;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      cand = r | (longint'(1) << b);
      if (cand * cand <= n) begin
        r = cand;
      end
    end
    return r;
  endfunction

  // v * lim / mag with the quotient truncated toward zero
  function automatic vel_t scale_down(vel_t v, longint lim, longint mag);
    longint a;
    longint q;
    a = longint'(v);
    if (a < 0) begin
      a = -a;
    end
    q = (a * lim) / mag;
    return (v < 0) ? vel_t'(-q) : vel_t'(q);
  endfunction

  function automatic velocity_t next_velocity(vel_t adj_x, vel_t adj_y);
    velocity_t r;
    longint    mag;
    longint    lim;
    r.vx = saturate_sum(cur_x, adj_x);
    r.vy = saturate_sum(cur_y, adj_y);
    mag = floor_root(longint'(r.vx) * longint'(r.vx) + longint'(r.vy) * longint'(r.vy));
    lim = longint'(speed_limit);
    r.clamped = (mag > lim);
    if (r.clamped) begin
      r.vx = scale_down(r.vx, lim, mag);
      r.vy = scale_down(r.vy, lim, mag);
    end
    cur_x = r.vx;
    cur_y = r.vy;
    return r;
  endfunction

  task automatic check_field(string field, logic signed [63:0] want_v, logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    velocity_t want;
    if (!rst_ni) begin
      cur_x = '0;
      cur_y = '0;
      speed_limit = MaxSpdReset;
      expected_vel_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        speed_limit = cfg_wdata_i;
      end
      // result side first: a result may leave at the edge the next item enters
      if (out_mon.valid && out_mon.ready) begin
        if (expected_vel_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result vel_x=%0d vel_y=%0d clamped=%0b", $time,
                   out_mon.vel_x, out_mon.vel_y, out_mon.clamped);
        end else begin
          want = expected_vel_q.pop_front();
          check_field("vel_x", want.vx, out_mon.vel_x);
          check_field("vel_y", want.vy, out_mon.vel_y);
          check_field("clamped", {63'd0, want.clamped}, {63'd0, out_mon.clamped});
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_vel_q.push_back(next_velocity(in_mon.x_adjust, in_mon.y_adjust));
      end
      fail_count_o <= mismatches;
      pending_o <= expected_vel_q.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// top of the limiter testbench: clock, reset, adjustment stimulus, flow control and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vml_pkg::*;

  localparam int unsigned VW           = VelWidthDef;
  localparam int unsigned PhaseItems   = 106;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles   = 64;

  typedef logic signed [VW-1:0] vel_t;

  localparam vel_t VelMax = {1'b0, {(VW-1){1'b1}}};
  localparam vel_t VelMin = {1'b1, {(VW-1){1'b0}}};
  localparam int unsigned SpdTop = (1 << MaxSpdBits) - 1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [MaxSpdBits-1:0] cfg_wdata_i;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_stall_pct = 0;
  int unsigned           limit_now;

  vml_in_if  in_if ();
  vml_out_if out_if ();

  velocity_magnitude_limiter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  vml_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls at random
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  // idle cycles come before valid rises; once up, valid and payload hold until the transfer
  task automatic put_adjust(input vel_t adj_x, input vel_t adj_y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.x_adjust <= adj_x;
    in_if.y_adjust <= adj_y;
    in_if.valid    <= 1'b1;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_limit(input int unsigned lim);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= lim[MaxSpdBits-1:0];
    limit_now = lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // most often steps up to about a quarter of the current limit, so the velocity wanders around it
  function automatic vel_t pick_adjust();
    int          span;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      span = int'(limit_now / 4) + 16;
    end else if (sel < 65) begin
      span = 4096;
    end else if (sel < 90) begin
      return vel_t'($urandom);
    end else begin
      case ($urandom_range(3))
        0: return VelMin;
        1: return VelMax;
        2: return vel_t'(-1);
        default: return vel_t'(1);
      endcase
    end
    return vel_t'(int'($urandom_range(2 * span)) - span);
  endfunction

  initial begin : stimulus
    int unsigned limits [8];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.x_adjust = '0;
    in_if.y_adjust = '0;
    limit_now = 32'(MaxSpdReset);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // limit at its reset value of 5.0
    put_adjust(vel_t'(0), vel_t'(0));
    put_adjust(vel_t'(1280), vel_t'(0));      // magnitude equal to the limit
    put_adjust(vel_t'(1), vel_t'(0));         // just over the limit
    put_adjust(vel_t'(-1280), vel_t'(0));
    put_adjust(vel_t'(768), vel_t'(1024));    // 3-4-5 triangle, exactly on the limit
    put_adjust(vel_t'(232), vel_t'(-224));    // true length between limit and limit + 1
    put_adjust(VelMax, VelMax);               // positive sum overflow
    put_adjust(VelMin, VelMin);
    put_adjust(VelMin, VelMin);               // negative sum overflow
    put_adjust(VelMax, VelMin);
    put_adjust(VelMin, VelMax);
    put_adjust(16'h5555, 16'hAAAA);
    put_adjust(vel_t'(-1), vel_t'(1));

    // zero limit squeezes any nonzero velocity to rest
    drain();
    set_limit(0);
    put_adjust(vel_t'(5), vel_t'(-3));
    put_adjust(vel_t'(0), vel_t'(0));
    put_adjust(VelMin, VelMax);

    drain();
    set_limit(SpdTop);
    put_adjust(VelMax, VelMax);
    put_adjust(VelMin, vel_t'(0));
    put_adjust(vel_t'(100), vel_t'(-100));

    limits = '{SpdTop, 1280, 0, 1, $urandom_range(SpdTop), SpdTop - 1, 5000,
               $urandom_range(2000)};
    for (int p = 0; p < 8; p++) begin
      drain();
      set_limit(limits[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct = 15;
          recv_stall_pct = 15;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        // hold off until the pipeline is empty, then resume
        if (n == PhaseItems / 2 && p % 2 == 1) begin
          drain();
        end
        put_adjust(pick_adjust(), pick_adjust());
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
